// File: hw/rtl/dms_pkg.sv
// Package for the disk mass subtraction block: item types, table entry type,
// configuration codes and the saturating accumulate helper. No dependencies.
package dms_pkg;

  localparam int MAX_DISKS = 64;
  localparam int IDX_W     = $clog2(MAX_DISKS);
  localparam int CNT_W     = $clog2(MAX_DISKS + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RAY  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [5:0]         entry_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        disk_radius;
    logic [30:0]        disk_density;
    logic signed [31:0] alpha_x_in;
    logic signed [31:0] alpha_y_in;
    logic signed [31:0] kappa_in;
    logic signed [31:0] gamma_1_in;
    logic signed [31:0] gamma_2_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] alpha_x_out;
    logic signed [31:0] alpha_y_out;
    logic signed [31:0] kappa_out;
    logic signed [31:0] gamma_1_out;
    logic signed [31:0] gamma_2_out;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        rad;
    logic [30:0]        dens;
  } disk_t;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] acc,
                                                 logic [63:0] mag, logic neg);
    logic signed [65:0] a;
    logic signed [65:0] b;
    logic signed [65:0] s;
    a = 66'(acc);
    b = $signed({2'b00, mag});
    s = neg ? (a - b) : (a + b);
    if (s > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return $signed(s[31:0]);
  endfunction

endpackage

// File: hw/rtl/dms_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on nothing.
module dms_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: hw/rtl/dms_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit quotient of a 96-bit
// numerator by a 65-bit divisor (quotient known to fit). Depends on nothing.
module dms_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [95:0] num_i,
  input  logic [64:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [64:0] rem_q;
  logic [31:0] low_q;
  logic [31:0] quo_q;
  logic [65:0] trial;
  logic [65:0] diff;

  assign trial = {rem_q, low_q[31]};
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[95:32]};
      low_q <= num_i[31:0];
    end else if (busy_q) begin
      low_q <= {low_q[30:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_q <= diff[64:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= trial[64:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hw/rtl/dms_mem.sv
// Disk table memory: one write port, one registered read port.
// Depends on dms_pkg.
module dms_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [dms_pkg::IDX_W-1:0]   waddr_i,
  input  dms_pkg::disk_t              wdata_i,
  input  logic                        re_i,
  input  logic [dms_pkg::IDX_W-1:0]   raddr_i,
  output dms_pkg::disk_t              rdata_o
);

  dms_pkg::disk_t mem [dms_pkg::MAX_DISKS];
  dms_pkg::disk_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lens_disk_mass_subtract.sv
// Lens disk mass subtraction: top level with sequencer and accumulators.
// Depends on dms_pkg, dms_mem, dms_mul, dms_div.
//
// A load item writes one disk entry and returns its alpha, kappa and gamma
// unchanged once the output register is free. A ray item, while enabled,
// walks the first region_count disks (clamped to 64) one after another
// through one shared 32x32 multiplier and one bit-serial divider; a disk that
// does not hold the ray (and is not centred on it) needs three 32-step
// divisions, which dominate. A ray while disabled or with no regions is unchanged.
// One item is in work at a time; in_stall_o is high meanwhile. The result
// sits in an output register, so the next item is taken while it waits.
module lens_disk_mass_subtract (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  dms_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dms_pkg::out_item_t              out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dms_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dms_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_DIFF = 5'd2;
  localparam logic [4:0] S_M1   = 5'd3;
  localparam logic [4:0] S_M2   = 5'd4;
  localparam logic [4:0] S_M3   = 5'd5;
  localparam logic [4:0] S_M4   = 5'd6;
  localparam logic [4:0] S_IN1  = 5'd7;
  localparam logic [4:0] S_IN2  = 5'd8;
  localparam logic [4:0] S_OB   = 5'd9;
  localparam logic [4:0] S_OC   = 5'd10;
  localparam logic [4:0] S_DS1  = 5'd11;
  localparam logic [4:0] S_DW1  = 5'd12;
  localparam logic [4:0] S_OE   = 5'd13;
  localparam logic [4:0] S_OF   = 5'd14;
  localparam logic [4:0] S_OG   = 5'd15;
  localparam logic [4:0] S_OH   = 5'd16;
  localparam logic [4:0] S_OI   = 5'd17;
  localparam logic [4:0] S_DS2  = 5'd18;
  localparam logic [4:0] S_DW2  = 5'd19;
  localparam logic [4:0] S_OK   = 5'd20;
  localparam logic [4:0] S_OL   = 5'd21;
  localparam logic [4:0] S_OM   = 5'd22;
  localparam logic [4:0] S_ON   = 5'd23;
  localparam logic [4:0] S_OO   = 5'd24;
  localparam logic [4:0] S_DS3  = 5'd25;
  localparam logic [4:0] S_DW3  = 5'd26;
  localparam logic [4:0] S_NEXT = 5'd27;
  localparam logic [4:0] S_DONE = 5'd28;

  localparam logic [dms_pkg::CNT_W-1:0] MaxCnt = dms_pkg::CNT_W'(dms_pkg::MAX_DISKS);

  logic [4:0]                 state_q, state_d;
  logic                       enable_q;
  logic [dms_pkg::CFG_W-1:0]  region_count_q;
  logic [dms_pkg::CNT_W-1:0]  idx_q, n_q;
  logic                       out_valid_q;
  dms_pkg::out_item_t         out_q;

  logic signed [31:0] rx_q, ry_q;
  logic signed [31:0] ax_q, ay_q, kp_q, g1_q, g2_q;
  logic [31:0]        mx_q, my_q, m_q;
  logic               nx_q, ny_q, sgn1_q;
  logic [63:0]        dx2_q, diff_q;
  logic [64:0]        d2_q;
  logic [61:0]        r2_q;
  logic [95:0]        t_q;

  logic               accept;
  logic               in_disk;
  logic [dms_pkg::CNT_W-1:0] n_in;
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic               div_start, div_done;
  logic [31:0]        div_quo;
  dms_pkg::disk_t     disk;
  dms_pkg::disk_t     wr_disk;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign n_in = (dms_pkg::CNT_W'(region_count_q) > MaxCnt) ? MaxCnt
                                                          : dms_pkg::CNT_W'(region_count_q);

  assign wr_disk.cx   = in_item_i.pos_x;
  assign wr_disk.cy   = in_item_i.pos_y;
  assign wr_disk.rad  = in_item_i.disk_radius;
  assign wr_disk.dens = in_item_i.disk_density;

  dms_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (accept && (in_item_i.action == dms_pkg::ACT_LOAD)),
    .waddr_i (in_item_i.entry_index[dms_pkg::IDX_W-1:0]),
    .wdata_i (wr_disk),
    .re_i    (state_q == S_RD),
    .raddr_i (idx_q[dms_pkg::IDX_W-1:0]),
    .rdata_o (disk)
  );

  dms_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign div_start = (state_q == S_DS1) || (state_q == S_DS2) || (state_q == S_DS3);

  dms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t_q),
    .den_i   (d2_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign dx  = 33'(disk.cx) - 33'(rx_q);
  assign dy  = 33'(disk.cy) - 33'(ry_q);
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);

  assign in_disk = d2_q < 65'(prod);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_M1: begin
        mul_a = mx_q;
        mul_b = mx_q;
      end
      S_M2: begin
        mul_a = my_q;
        mul_b = my_q;
      end
      S_M3: begin
        mul_a = 32'(disk.rad);
        mul_b = 32'(disk.rad);
      end
      S_M4: begin
        mul_a = 32'(disk.dens);
        mul_b = in_disk ? mx_q : prod[31:0];
      end
      S_IN1: begin
        mul_a = 32'(disk.dens);
        mul_b = my_q;
      end
      S_OB: begin
        mul_a = 32'(disk.dens);
        mul_b = 32'(r2_q[61:32]);
      end
      S_OE: begin
        mul_a = m_q;
        mul_b = mx_q;
      end
      S_OF: begin
        mul_a = m_q;
        mul_b = my_q;
      end
      S_OG, S_OM: begin
        mul_a = m_q;
        mul_b = diff_q[31:0];
      end
      S_OH, S_ON: begin
        mul_a = m_q;
        mul_b = diff_q[63:32];
      end
      S_OK: begin
        mul_a = mx_q;
        mul_b = my_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((in_item_i.action == dms_pkg::ACT_RAY) && enable_q && (n_in != '0)) begin
            state_d = S_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RD:   state_d = S_DIFF;
      S_DIFF: state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4: begin
        if (in_disk) begin
          state_d = S_IN1;
        end else if (d2_q == '0) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_OB;
        end
      end
      S_IN1:  state_d = S_IN2;
      S_IN2:  state_d = S_NEXT;
      S_OB:   state_d = S_OC;
      S_OC:   state_d = S_DS1;
      S_DS1:  state_d = S_DW1;
      S_DW1:  state_d = div_done ? S_OE : S_DW1;
      S_OE:   state_d = S_OF;
      S_OF:   state_d = S_OG;
      S_OG:   state_d = S_OH;
      S_OH:   state_d = S_OI;
      S_OI:   state_d = S_DS2;
      S_DS2:  state_d = S_DW2;
      S_DW2:  state_d = div_done ? S_OK : S_DW2;
      S_OK:   state_d = S_OL;
      S_OL:   state_d = S_OM;
      S_OM:   state_d = S_ON;
      S_ON:   state_d = S_OO;
      S_OO:   state_d = S_DS3;
      S_DS3:  state_d = S_DW3;
      S_DW3:  state_d = div_done ? S_NEXT : S_DW3;
      S_NEXT: state_d = (idx_q + 1'b1 == n_q) ? S_DONE : S_RD;
      S_DONE: state_d = (!out_valid_q || !out_stall_i) ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      enable_q       <= 1'b0;
      region_count_q <= '0;
      out_valid_q    <= 1'b0;
      idx_q          <= '0;
      n_q            <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          dms_pkg::CFG_ENABLE:       enable_q <= cfg_data_i[0];
          dms_pkg::CFG_REGION_COUNT: region_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        idx_q <= '0;
        n_q   <= n_in;
      end else if (state_q == S_NEXT) begin
        idx_q <= idx_q + 1'b1;
      end
      if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rx_q <= in_item_i.pos_x;
      ry_q <= in_item_i.pos_y;
      ax_q <= in_item_i.alpha_x_in;
      ay_q <= in_item_i.alpha_y_in;
      kp_q <= in_item_i.kappa_in;
      g1_q <= in_item_i.gamma_1_in;
      g2_q <= in_item_i.gamma_2_in;
    end
    unique case (state_q)
      S_DIFF: begin
        mx_q <= adx[31:0];
        my_q <= ady[31:0];
        nx_q <= dx[32];
        ny_q <= dy[32];
      end
      S_M2: dx2_q <= prod;
      S_M3: begin
        d2_q   <= 65'(dx2_q) + 65'(prod);
        diff_q <= (dx2_q >= prod) ? (dx2_q - prod) : (prod - dx2_q);
        sgn1_q <= dx2_q < prod;
      end
      S_M4: r2_q <= prod[61:0];
      S_IN1: ax_q <= dms_pkg::sat_add(ax_q, {16'd0, prod[63:16]}, nx_q);
      S_IN2: begin
        ay_q <= dms_pkg::sat_add(ay_q, {16'd0, prod[63:16]}, ny_q);
        kp_q <= dms_pkg::sat_add(kp_q, 64'(disk.dens), 1'b1);
      end
      S_OB, S_OH, S_ON: t_q <= 96'(prod);
      S_OC, S_OI: t_q <= t_q + {prod, 32'd0};
      S_OO: t_q <= (t_q + {prod, 32'd0}) << 1;
      S_DW1: begin
        if (div_done) begin
          m_q <= div_quo;
        end
      end
      S_OF: ax_q <= dms_pkg::sat_add(ax_q, {16'd0, prod[63:16]}, nx_q);
      S_OG: ay_q <= dms_pkg::sat_add(ay_q, {16'd0, prod[63:16]}, ny_q);
      S_DW2: begin
        if (div_done) begin
          g1_q <= dms_pkg::sat_add(g1_q, 64'(div_quo), sgn1_q);
        end
      end
      S_OL: diff_q <= prod;
      S_DW3: begin
        if (div_done) begin
          g2_q <= dms_pkg::sat_add(g2_q, 64'(div_quo), nx_q ^ ny_q);
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_q.alpha_x_out <= ax_q;
          out_q.alpha_y_out <= ay_q;
          out_q.kappa_out   <= kp_q;
          out_q.gamma_1_out <= g1_q;
          out_q.gamma_2_out <= g2_q;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DW1 || state_q == S_DW2 || state_q == S_DW3))
    else $error("divider finished outside a wait state");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (idx_q < n_q && n_q <= MaxCnt))
    else $error("disk walk index out of range");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished item not moved to output register");
`endif

endmodule
